[design/mspg_pkg.sv]
package mspg_pkg;

    localparam int MASK_W  = 7;
    localparam int POS_W   = 32;
    localparam int CNT_W   = 24;
    localparam int AXIS_W  = 3;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 4;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_NUDGE = 2'd1;
    localparam logic [1:0] OP_SET   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ALWAYS_ON = 4'd0;

    localparam logic [CNT_W-1:0] TIMEOUT_RESET = 24'd6666;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_RD,
        ST_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [AXIS_W-1:0]       axis_index;
        logic                    nudge_up;
        logic signed [POS_W-1:0] target_value;
    } t_in_word;

    typedef struct packed {
        logic [MASK_W-1:0]       step_mask;
        logic [MASK_W-1:0]       dir_mask;
        logic [MASK_W-1:0]       enable_mask;
        logic signed [POS_W-1:0] position;
        logic                    at_target;
    } t_out_word;

    // One memory word per axis.
    typedef struct packed {
        logic [CNT_W-1:0] idle_count;
        logic [POS_W-1:0] target;
        logic [POS_W-1:0] current;
    } t_axis_word;

endpackage

[design/multi_axis_step_pulse_generator.sv]
// A tick word sweeps every axis: one axis is read, updated and written back per memory
// cycle, then the addressed axis is read once more for the readback. A nudge, set or
// unused opcode goes straight to that readback. One word is in work at a time: the next
// is taken only after the result word of the last has moved into the output register.
// Synchronous active-low reset clears the state machine, the per-axis flags and the memory
// valid bits, so every axis reads back as all zero.
module multi_axis_step_pulse_generator
    import mspg_pkg::*;
#(
    parameter int AXES = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input word channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in,
    // result word channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int CW = $clog2(AXES + 1);
    localparam int MW = $bits(t_axis_word);
    localparam logic [AXIS_W-1:0] AXES_A = AXIS_W'(AXES);
    localparam logic [CW-1:0]     AXES_C = CW'(AXES);

    // Configuration registers. Timeout registers beyond the axis count are never read,
    // so they are not kept.
    logic [MASK_W-1:0] r_always_on;
    logic [CNT_W-1:0]  r_timeout [AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_always_on <= '0;
            for (int i = 0; i < AXES; i++) begin
                r_timeout[i] <= TIMEOUT_RESET;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_ALWAYS_ON) begin
                r_always_on <= i_cfg_data[MASK_W-1:0];
            end
            for (int i = 0; i < AXES; i++) begin
                if (i_cfg_index == CFG_IDX_W'(i + 1)) begin
                    r_timeout[i] <= i_cfg_data[CNT_W-1:0];
                end
            end
        end
    end

    // Control state and the small per-axis flags that feed the pin masks directly.
    t_state           r_state, n_state;
    t_in_word         r_item;
    logic [CW-1:0]    r_idx;      // next axis to read during a tick
    logic             r_pv;       // memory data for r_pidx arrives this cycle
    logic [AW-1:0]    r_pidx;
    t_phase           r_phase [AXES];
    logic [AXES-1:0]  r_en;
    logic [AXES-1:0]  r_dir;
    logic [AXES-1:0]  r_vld;      // memory entry written since reset
    logic             r_rv;       // valid bit of the entry being read
    logic             r_ov;
    t_out_word        r_out;
    t_out_word        r_res;

    // Memory port controls.
    logic             w_we;
    logic [AW-1:0]    w_wr_addr;
    t_axis_word       w_wr_data;
    logic [AW-1:0]    w_rd_addr;
    logic [MW-1:0]    w_rd_raw;
    t_axis_word       w_q;

    logic             w_accept;
    logic             w_out_free;
    logic             w_axis_ok;
    logic             w_edit;
    logic             w_tick_last;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_ov || !i_out_stall;
    assign w_axis_ok  = r_item.axis_index < AXES_A;
    assign w_edit     = w_axis_ok &&
                        (r_item.opcode == OP_NUDGE || r_item.opcode == OP_SET);
    assign w_tick_last = r_pv && (r_idx == AXES_C);

    mspg_ram #(
        .WIDTH (MW),
        .DEPTH (AXES)
    ) u_axis_mem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    // An entry never written reads as the reset value, all zero.
    assign w_q = r_rv ? t_axis_word'(w_rd_raw) : '0;

    // Tick update of the axis whose data is at the memory output.
    t_phase           n_phase;
    logic             n_en;
    logic             n_dir;
    t_axis_word       n_tick_word;
    logic             w_sgt;

    assign w_sgt = $signed(w_q.target) > $signed(w_q.current);

    always_comb begin
        n_phase     = r_phase[r_pidx];
        n_en        = r_en[r_pidx];
        n_dir       = r_dir[r_pidx];
        n_tick_word = w_q;
        unique case (r_phase[r_pidx])
            PH_HIGH: begin
                // Target may have moved during the pulse; step up if above, else down.
                n_tick_word.current = w_sgt ? w_q.current + 1'b1 : w_q.current - 1'b1;
                n_phase             = PH_LOW;
            end
            PH_LOW: begin
                n_phase = PH_IDLE;
            end
            PH_IDLE: begin
                if (w_q.current != w_q.target) begin
                    n_tick_word.idle_count = '0;
                    n_en                   = 1'b1;
                    n_dir                  = w_sgt;
                    n_phase                = PH_HIGH;
                end else if (!r_always_on[r_pidx]) begin
                    if (w_q.idle_count < r_timeout[r_pidx]) begin
                        n_tick_word.idle_count = w_q.idle_count + 1'b1;
                    end else begin
                        n_en = 1'b0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Nudge or set of the addressed axis target.
    t_axis_word       n_edit_word;

    always_comb begin
        n_edit_word = w_q;
        if (r_item.opcode == OP_SET) begin
            n_edit_word.target = r_item.target_value;
        end else if (r_item.nudge_up) begin
            n_edit_word.target = w_q.target + 1'b1;
        end else begin
            n_edit_word.target = w_q.target - 1'b1;
        end
    end

    // Result word, formed once all state for the item is final.
    logic [MASK_W-1:0] w_step_mask;
    logic [MASK_W-1:0] w_dir_mask;
    logic [MASK_W-1:0] w_en_mask;

    always_comb begin
        w_step_mask = '0;
        w_dir_mask  = '0;
        w_en_mask   = '0;
        for (int i = 0; i < AXES; i++) begin
            w_step_mask[i] = r_phase[i] == PH_HIGH;
            w_dir_mask[i]  = r_dir[i];
            w_en_mask[i]   = r_en[i];
        end
    end

    t_out_word n_res;

    always_comb begin
        n_res.step_mask   = w_step_mask;
        n_res.dir_mask    = w_dir_mask;
        n_res.enable_mask = w_en_mask;
        n_res.position    = '0;
        n_res.at_target   = 1'b0;
        if (w_axis_ok) begin
            n_res.position = w_q.current;
            if (w_edit) begin
                n_res.at_target = w_q.current == n_edit_word.target;
            end else begin
                n_res.at_target = w_q.current == w_q.target;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in.opcode == OP_TICK) ? ST_TICK : ST_RD;
                end
            end
            ST_TICK: begin
                if (w_tick_last) begin
                    n_state = ST_RD;
                end
            end
            ST_RD:   n_state = ST_FIN;
            ST_FIN:  n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: memory port and handshake.
    always_comb begin
        o_in_stall = 1'b1;
        w_we       = 1'b0;
        w_wr_addr  = r_item.axis_index[AW-1:0];
        w_wr_data  = n_edit_word;
        w_rd_addr  = r_item.axis_index[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_TICK: begin
                w_we      = r_pv;
                w_wr_addr = r_pidx;
                w_wr_data = n_tick_word;
                w_rd_addr = (r_idx < AXES_C) ? r_idx[AW-1:0] : '0;
            end
            ST_FIN: begin
                w_we = w_edit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_pv    <= 1'b0;
            r_en    <= '0;
            r_dir   <= '0;
            r_vld   <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_phase[i] <= PH_IDLE;
            end
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_idx <= '0;
                r_pv  <= 1'b0;
            end else if (r_state == ST_TICK) begin
                r_pv <= r_idx < AXES_C;
                if (r_idx < AXES_C) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (r_state == ST_TICK && r_pv) begin
                r_phase[r_pidx] <= n_phase;
                r_en[r_pidx]    <= n_en;
                r_dir[r_pidx]   <= n_dir;
            end
            if (w_we) begin
                r_vld[w_wr_addr] <= 1'b1;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rv <= r_vld[w_rd_addr];
        if (r_state == ST_TICK) begin
            r_pidx <= r_idx[AW-1:0];
        end
        if (w_accept) begin
            r_item <= i_in;
        end
        if (r_state == ST_FIN) begin
            r_res <= n_res;
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    // A step pulse is only ever raised on an energized driver.
    a_step_energized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step_mask & ~w_en_mask) == '0)
        else $error("step pulse on a de-energized axis");

    // The memory is written only while an item is being worked on.
    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_TICK || r_state == ST_FIN))
        else $error("axis memory written outside item work");

    // The tick sweep never runs past the last axis.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= AXES_C)
        else $error("tick sweep index out of range");

    // A new result word is only produced by the hand-off state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(r_state == ST_DONE))
        else $error("result word appeared without hand-off");

    // No input word is taken while a sweep is in progress.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK) |-> o_in_stall)
        else $error("input accepted during tick sweep");

endmodule

[design/mspg_ram.sv]
module mspg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

// Regression bench for the seven-axis step/direction pulse generator.
// A behavioral copy of the per-axis state sits in this module and is advanced
// once for every input word that the block accepts. The expected result word
// goes into a queue. A checker at the output compares each accepted result
// word with the oldest queued one.
module testbench;
    import mspg_pkg::*;

    localparam int NUM_AXES     = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 200;

    // The package names three operations; the fourth encoding must do nothing.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Timeout registers follow the always-on mask, one per axis. Index 15 is
    // not mapped to anything and must be ignored by the block.
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_BASE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED     = 4'd15;

    typedef enum int {
        LIMITS_SMALL,
        LIMITS_ZERO,
        LIMITS_MAX,
        LIMITS_MIXED
    } t_limit_mode;

    // Block ports. Every input holds a known value from time zero.
    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // Shadow copy of the axis state and of the configuration registers.
    t_phase           phase_of      [NUM_AXES];
    logic [POS_W-1:0] cur_pos       [NUM_AXES];
    logic [POS_W-1:0] tgt_pos       [NUM_AXES];
    logic [CNT_W-1:0] rest_run      [NUM_AXES];
    logic             energized     [NUM_AXES];
    logic             dir_up        [NUM_AXES];
    logic [CNT_W-1:0] timeout_ticks [NUM_AXES];
    logic [MASK_W-1:0] hold_on_mask;

    // Result words still owed by the block, oldest first.
    t_out_word pending_outputs [$];

    int words_sent     = 0;
    int words_checked  = 0;
    int mismatch_count = 0;
    int settings_count = 0;
    int cycle_count    = 0;

    // Idle controls: each side draws a wait of 0 to its maximum per word.
    // A maximum of zero gives a stretch of back-to-back traffic.
    int tx_gap_max  = 0;
    int rx_gap_max  = 0;
    // When nonzero, the receiver stalls for this many cycles in one piece.
    int rx_hold_len = 0;

    multi_axis_step_pulse_generator #(
        .AXES(NUM_AXES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d result words still owed",
                     cycle_count, pending_outputs.size());
            $display("multi_axis_step_pulse_generator regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Behavioral model of the axes
    // ------------------------------------------------------------------

    // State after reset: every axis idle at zero, de-energized, and the
    // registers at their reset values.
    function automatic void clear_axes();
        for (int a = 0; a < NUM_AXES; a++) begin
            phase_of[a]      = PH_IDLE;
            cur_pos[a]       = '0;
            tgt_pos[a]       = '0;
            rest_run[a]      = '0;
            energized[a]     = 1'b0;
            dir_up[a]        = 1'b0;
            timeout_ticks[a] = TIMEOUT_RESET;
        end
        hold_on_mask = '0;
    endfunction

    // One tick of time for all axes. Each axis walks idle -> high -> low.
    // The move happens on leaving the high phase, and its direction is taken
    // from the target at that moment, so a target moved during a pulse can
    // turn the step around. A target equal to the position at that moment
    // still gives a step down.
    function automatic void tick_axes();
        logic climbing;
        for (int a = 0; a < NUM_AXES; a++) begin
            climbing = $signed(tgt_pos[a]) > $signed(cur_pos[a]);
            case (phase_of[a])
                PH_HIGH: begin
                    cur_pos[a]  = climbing ? cur_pos[a] + 32'd1 : cur_pos[a] - 32'd1;
                    phase_of[a] = PH_LOW;
                end
                PH_LOW: begin
                    phase_of[a] = PH_IDLE;
                end
                default: begin
                    if (cur_pos[a] != tgt_pos[a]) begin
                        rest_run[a]   = '0;
                        energized[a]  = 1'b1;
                        dir_up[a]     = climbing;
                        phase_of[a]   = PH_HIGH;
                    end else if (!hold_on_mask[a]) begin
                        // The counter saturates at the timeout; one more idle
                        // tick after that drops the driver enable.
                        if (rest_run[a] < timeout_ticks[a]) begin
                            rest_run[a] = rest_run[a] + 1'b1;
                        end else begin
                            energized[a] = 1'b0;
                        end
                    end
                end
            endcase
        end
    endfunction

    // Applies one accepted word to the shadow state and returns the result
    // word the block must produce for it.
    function automatic t_out_word apply_word(t_in_word w);
        t_out_word r;
        logic      in_range;
        in_range = w.axis_index < NUM_AXES;
        if (w.opcode == OP_TICK) begin
            tick_axes();
        end else if (w.opcode == OP_NUDGE && in_range) begin
            tgt_pos[w.axis_index] = w.nudge_up ? tgt_pos[w.axis_index] + 32'd1
                                               : tgt_pos[w.axis_index] - 32'd1;
        end else if (w.opcode == OP_SET && in_range) begin
            tgt_pos[w.axis_index] = w.target_value;
        end
        r = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            r.step_mask[a]   = phase_of[a] == PH_HIGH;
            r.dir_mask[a]    = dir_up[a];
            r.enable_mask[a] = energized[a];
        end
        // An axis index past the last axis reads back as zero.
        if (in_range) begin
            r.position  = cur_pos[w.axis_index];
            r.at_target = cur_pos[w.axis_index] == tgt_pos[w.axis_index];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_in_word make_word(logic [1:0] op, logic [AXIS_W-1:0] ax,
                                           logic up, logic [POS_W-1:0] val);
        t_in_word w;
        w.opcode       = op;
        w.axis_index   = ax;
        w.nudge_up     = up;
        w.target_value = val;
        return w;
    endfunction

    // Random traffic is mostly ticks and targets close to where the axis
    // stands, so that pulses start, finish, reverse and time out often.
    // The rest is far targets, nudges, the unused opcode and words for the
    // axis index past the last axis. Fields that an operation ignores are
    // still random so that every input bit toggles.
    function automatic t_in_word random_word();
        t_in_word          w;
        int                pick;
        logic [AXIS_W-1:0] ax;
        w.opcode       = OP_TICK;
        w.axis_index   = AXIS_W'($urandom_range(NUM_AXES, 0));
        w.nudge_up     = 1'($urandom_range(1, 0));
        w.target_value = $urandom;
        pick = $urandom_range(99, 0);
        ax = ($urandom_range(19, 0) == 0) ? AXIS_W'(NUM_AXES)
                                           : AXIS_W'($urandom_range(NUM_AXES - 1, 0));
        if (pick < 55) begin
            w.opcode = OP_TICK;
        end else if (pick < 70) begin
            w.opcode     = OP_NUDGE;
            w.axis_index = ax;
        end else if (pick < 88) begin
            w.opcode     = OP_SET;
            w.axis_index = ax;
            if (ax < NUM_AXES) begin
                w.target_value = cur_pos[ax] + $urandom_range(12, 0) - 32'd6;
            end
        end else if (pick < 96) begin
            w.opcode     = OP_SET;
            w.axis_index = ax;
        end else begin
            w.opcode = OP_UNUSED;
        end
        return w;
    endfunction

    // Offers one word and returns right after the edge that accepts it.
    // The valid line is lowered only when a gap is drawn, so a word that
    // follows at once keeps valid high without a glitch.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_outputs.push_back(apply_word(w));
        words_sent++;
    endtask

    // Stops offering words and waits until every owed result has arrived.
    // Every word produces a result, so an empty queue means the block is idle.
    task automatic wait_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_ALWAYS_ON) begin
            hold_on_mask = value[MASK_W-1:0];
        end else if (idx >= REG_TIMEOUT_BASE && idx < REG_TIMEOUT_BASE + NUM_AXES) begin
            timeout_ticks[idx - REG_TIMEOUT_BASE] = value;
        end
    endtask

    // Writes every register once the block has gone quiet. Small timeouts
    // make de-energizing frequent; the maximum makes it practically never
    // happen; the mixed mode puts full-range values on some axes.
    task automatic configure(input logic [MASK_W-1:0] mask, input t_limit_mode mode);
        logic [CNT_W-1:0] limit;
        wait_results();
        write_reg(REG_ALWAYS_ON, CFG_W'(mask));
        for (int a = 0; a < NUM_AXES; a++) begin
            case (mode)
                LIMITS_ZERO: begin
                    limit = '0;
                end
                LIMITS_MAX: begin
                    limit = '1;
                end
                LIMITS_MIXED: begin
                    limit = $urandom_range(1, 0) ? CNT_W'($urandom)
                                                 : CNT_W'($urandom_range(12, 0));
                end
                default: begin
                    limit = CNT_W'($urandom_range(6, 0));
                end
            endcase
            write_reg(CFG_IDX_W'(REG_TIMEOUT_BASE + a), limit);
        end
        write_reg(REG_UNMAPPED, CFG_W'($urandom));
        settings_count++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every operation, the unused opcode, the axis index past the last axis,
    // and targets at both ends of the signed range. Runs on the reset
    // register values.
    task automatic test_opcode_sweep();
        tx_gap_max = 10;
        rx_gap_max = 10;
        send_word(make_word(OP_TICK, '0, 1'b0, '0));
        send_word(make_word(OP_UNUSED, AXIS_W'(NUM_AXES), 1'b1, '1));
        send_word(make_word(OP_SET, AXIS_W'(NUM_AXES), 1'b0, 32'd123));
        send_word(make_word(OP_NUDGE, AXIS_W'(NUM_AXES), 1'b1, '0));
        send_word(make_word(OP_SET, 3'd0, 1'b0, 32'h7FFF_FFFF));
        send_word(make_word(OP_SET, 3'd6, 1'b1, 32'h8000_0000));
        repeat (3) send_word(make_word(OP_TICK, 3'd0, 1'b0, 32'h5555_5555));
        send_word(make_word(OP_SET, 3'd0, 1'b0, '0));
        send_word(make_word(OP_SET, 3'd6, 1'b0, '0));
        send_word(make_word(OP_NUDGE, 3'd2, 1'b1, 32'hAAAA_AAAA));
        send_word(make_word(OP_NUDGE, 3'd2, 1'b0, 32'h5555_5555));
        repeat (2) send_word(make_word(OP_TICK, 3'd6, 1'b1, '1));
    endtask

    // Retargets an axis while its step pulse is high: once to the other side
    // so the step reverses, once to the current position so it steps down.
    // Runs with zero timeouts and every other axis held on, so idle axes
    // either drop their enable at once or keep it.
    task automatic test_retarget_midpulse();
        send_word(make_word(OP_SET, 3'd3, 1'b0, 32'd4));
        send_word(make_word(OP_TICK, 3'd3, 1'b0, '0));
        send_word(make_word(OP_SET, 3'd3, 1'b0, -32'sd4));
        send_word(make_word(OP_TICK, 3'd3, 1'b0, '0));
        send_word(make_word(OP_SET, 3'd4, 1'b1, 32'd1));
        send_word(make_word(OP_TICK, 3'd4, 1'b0, '0));
        send_word(make_word(OP_SET, 3'd4, 1'b0, '0));
        repeat (2) send_word(make_word(OP_TICK, 3'd4, 1'b0, '0));
    endtask

    // The receiver stalls for a long stretch while the sender keeps offering
    // back to back, so the block fills and stalls its input. Afterwards the
    // sender pauses until every result is back.
    task automatic test_backpressure();
        tx_gap_max  = 0;
        rx_gap_max  = 0;
        rx_hold_len = HOLD_CYCLES;
        for (int k = 0; k < 12; k++) begin
            send_word(random_word());
        end
        wait_results();
    endtask

    // Random traffic. Every fifty words each side picks again between
    // back-to-back operation and random gaps.
    task automatic test_random_traffic(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 50 == 0) begin
                tx_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 10;
                rx_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 10;
            end
            send_word(random_word());
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: draws a stall per result word, or takes a requested hold
    // ------------------------------------------------------------------
    initial begin : result_receiver
        int n;
        forever begin
            if (rx_hold_len > 0) begin
                n = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                n = $urandom_range(rx_gap_max, 0);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted result word against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void report_bad(string what, t_out_word want, t_out_word got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] %s: step %h/%h dir %h/%h en %h/%h pos %0d/%0d at %b/%b (exp/got)",
                     $realtime, what, want.step_mask, got.step_mask, want.dir_mask,
                     got.dir_mask, want.enable_mask, got.enable_mask, want.position,
                     got.position, want.at_target, got.at_target);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outputs.size() == 0) begin
                report_bad("unexpected result word", '0, o_out);
            end else begin
                want = pending_outputs.pop_front();
                words_checked++;
                if (o_out.step_mask !== want.step_mask || o_out.dir_mask !== want.dir_mask
                    || o_out.enable_mask !== want.enable_mask
                    || o_out.position !== want.position
                    || o_out.at_target !== want.at_target) begin
                    report_bad("result word mismatch", want, o_out);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        clear_axes();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_opcode_sweep();
        configure(7'h55, LIMITS_ZERO);
        test_retarget_midpulse();

        configure(MASK_W'($urandom), LIMITS_SMALL);
        test_random_traffic(180);
        test_backpressure();

        configure(7'h7F, LIMITS_MAX);
        test_random_traffic(130);
        configure(7'h00, LIMITS_ZERO);
        test_random_traffic(150);
        configure(MASK_W'($urandom), LIMITS_MIXED);
        test_random_traffic(150);
        configure(7'h00, LIMITS_SMALL);
        test_random_traffic(140);

        // Let any stray output show up before the verdict.
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d words over %0d register settings plus reset values;",
                 words_sent, settings_count);
        $display("%0d results checked, %0d mismatches, %0d results never seen.",
                 words_checked, mismatch_count, pending_outputs.size());
        if (mismatch_count == 0 && pending_outputs.size() == 0) begin
            $display("multi_axis_step_pulse_generator regression: pass");
        end else begin
            $display("multi_axis_step_pulse_generator regression: fail");
        end
        $finish;
    end

endmodule

[multi_axis_step_pulse_generator.f]
design/mspg_pkg.sv
design/mspg_ram.sv
design/multi_axis_step_pulse_generator.sv
tb/sv/testbench.sv
